/* sv/voxel_grid_count_mean_height_assert.svh */
// Assertion macros for the voxel grid counter.
// Included by the top level; no other dependencies.
`ifndef VOXEL_GRID_COUNT_MEAN_HEIGHT_ASSERT_SVH
`define VOXEL_GRID_COUNT_MEAN_HEIGHT_ASSERT_SVH
`define VG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define VG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

/* sv/vgcmh_pkg.sv */
// Shared types and codes for the voxel grid counter.
// No dependencies.
package vgcmh_pkg;
  localparam int CoordW = 21;
  localparam int SizeW  = 20;
  localparam int TotalW = 24;
  localparam int NumRegs = 7;
  localparam logic [2:0] RegXLow = 3'd0;
  localparam logic [2:0] RegXHigh = 3'd1;
  localparam logic [2:0] RegYLow = 3'd2;
  localparam logic [2:0] RegYHigh = 3'd3;
  localparam logic [2:0] RegZLow = 3'd4;
  localparam logic [2:0] RegZHigh = 3'd5;
  localparam logic [2:0] RegVSize = 3'd6;
  localparam logic [1:0] StAdded = 2'd0;
  localparam logic [1:0] StOutside = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StTooBig = 2'd3;
endpackage

/* sv/vgcmh_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses vgcmh_pkg for nothing beyond style; standalone.
module vgcmh_div import vgcmh_pkg::*; #(
  parameter int NW = 38,
  parameter int DW = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW:0] trial;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {r_q, q_q[NW-1]};
    if (start_i) begin
      q_d = num_i;
      r_d = '0;
      cnt_d = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        r_d = trial[DW-1:0] - den_q;
        q_d = {q_q[NW-2:0], 1'b1};
      end else begin
        r_d = trial[DW-1:0];
        q_d = {q_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o = q_q;
endmodule

/* sv/vgcmh_mul.sv */
// Shift-add serial multiplier, one multiplier bit per cycle.
// Standalone; imports vgcmh_pkg.
module vgcmh_mul import vgcmh_pkg::*; #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);
  localparam int CW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc_q, a_q;
  logic [BW-1:0] b_q;
  logic [CW-1:0] cnt_q;
  logic busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q <= (AW+BW)'(a_i);
      b_q <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

/* sv/voxel_grid_count_mean_height.sv */
// Voxel grid counter: one point per item, one result beat per item.
// For a binned point the steps are three grid divides, two size products, three
// cell divides, one index product, read, update and the mean divide; when the grid
// is too big or the point is outside, the result beat follows the size products.
// After the result beat is taken the block returns to idle, and only then takes the next point.
// Reset clears registers at once, then a clearing pass zeroes all MAX_VOXELS store entries.
`include "voxel_grid_count_mean_height_assert.svh"
module voxel_grid_count_mean_height import vgcmh_pkg::*; #(
  parameter int MAX_VOXELS = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [CoordW-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               status_o,
  output logic [11:0]              voxel_index_o,
  output logic [15:0]              voxel_points_o,
  output logic signed [CoordW-1:0] voxel_mean_z_o,
  output logic [TotalW-1:0]        total_points_o
);
  localparam int AW = $clog2(MAX_VOXELS);
  localparam int SW = 38;
  localparam int DNW = 38;
  localparam int PW = 24;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_DIM = 4'd2, S_DIMW = 4'd3,
    S_SZ1 = 4'd4, S_SZ1W = 4'd5, S_SZ2 = 4'd6, S_SZ2W = 4'd7, S_CELL = 4'd8,
    S_CELLW = 4'd9, S_IX1 = 4'd10, S_IX1W = 4'd11, S_RD = 4'd12, S_UPD = 4'd13,
    S_MEANW = 4'd14, S_OUT = 4'd15;

  logic [3:0] st_q;
  logic signed [CoordW-1:0] xl_q, xh_q, yl_q, yh_q, zl_q, zh_q;
  logic [SizeW-1:0] vs_q;
  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic [1:0] ax_q;
  logic [PW-1:0] dim_q [3];
  logic [PW-1:0] cell_q [3];
  logic [AW-1:0] clr_q;
  logic [TotalW-1:0] tot_q;
  logic [1:0] stat_q;
  logic [AW-1:0] idx_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic signed [CoordW-1:0] mean_q;
  logic neg_q;
  logic ovf_q;
  logic [COUNT_BITS-1:0] cmem [MAX_VOXELS];
  logic signed [SW-1:0] smem [MAX_VOXELS];
  logic [COUNT_BITS-1:0] crd_q;
  logic signed [SW-1:0] srd_q;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [COUNT_BITS-1:0] mem_wc;
  logic signed [SW-1:0] mem_ws;

  // new count and sum of the addressed voxel, held when it is full
  logic upd_full;
  logic [COUNT_BITS-1:0] upd_cnt;
  logic signed [SW-1:0] upd_sum;
  assign upd_full = (crd_q == CntMax);
  assign upd_cnt = upd_full ? crd_q : crd_q + 1'b1;
  assign upd_sum = upd_full ? srd_q : srd_q + SW'(pz_q);

  // shared divider and multiplier
  logic dv_start, dv_done, mu_start, mu_done;
  logic [DNW-1:0] dv_num, dv_quo;
  logic [SizeW-1:0] dv_den;
  logic [PW-1:0] mu_a, mu_b;
  logic [2*PW-1:0] mu_p;
  logic [SizeW-1:0] vs_eff;
  logic signed [CoordW-1:0] lo_s, hi_s, pt_s;
  logic [CoordW:0] span;

  assign vs_eff = (vs_q == '0) ? SizeW'(1) : vs_q;

  always_comb begin
    unique case (ax_q)
      2'd0: begin lo_s = CoordW'(xl_q); hi_s = CoordW'(xh_q); pt_s = CoordW'(px_q); end
      2'd1: begin lo_s = CoordW'(yl_q); hi_s = CoordW'(yh_q); pt_s = CoordW'(py_q); end
      default: begin lo_s = CoordW'(zl_q); hi_s = CoordW'(zh_q); pt_s = CoordW'(pz_q); end
    endcase
  end

  logic signed [CoordW:0] lo_x, hi_x, pt_x;
  assign lo_x = {lo_s[CoordW-1], lo_s[CoordW-1:0]};
  assign hi_x = {hi_s[CoordW-1], hi_s[CoordW-1:0]};
  assign pt_x = {pt_s[CoordW-1], pt_s[CoordW-1:0]};
  logic [CoordW:0] dspan, pspan;
  assign dspan = hi_x - lo_x;
  assign pspan = pt_x - lo_x;

  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = vs_eff;
    mu_start = 1'b0;
    mu_a = '0;
    mu_b = '0;
    span = '0;
    unique case (st_q)
      S_DIM: begin
        dv_start = 1'b1;
        span = (hi_x > lo_x) ? dspan : '0;
        dv_num = DNW'(span) + DNW'(vs_eff) - DNW'(1);
      end
      S_CELL: begin
        dv_start = 1'b1;
        dv_num = DNW'(pspan);
      end
      S_SZ1: begin mu_start = 1'b1; mu_a = dim_q[0]; mu_b = dim_q[1]; end
      S_SZ2: begin mu_start = 1'b1; mu_a = mu_p[PW-1:0]; mu_b = dim_q[2]; end
      S_IX1: begin mu_start = 1'b1; mu_a = cell_q[0]; mu_b = dim_q[1]; end
      S_UPD: begin
        dv_start = 1'b1;
        dv_den = SizeW'(upd_cnt);
        dv_num = upd_sum[SW-1] ? DNW'(-upd_sum) : DNW'(upd_sum);
      end
      default: ;
    endcase
  end

  vgcmh_div #(.NW(DNW), .DW(SizeW)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );
  vgcmh_mul #(.AW(PW), .BW(PW)) u_mul (
    .clk_i, .rst_ni, .start_i(mu_start), .a_i(mu_a), .b_i(mu_b),
    .done_o(mu_done), .prod_o(mu_p)
  );

  logic outside, sat_dim;
  assign outside = (px_q < xl_q) || (px_q > xh_q) || (py_q < yl_q) || (py_q > yh_q)
                || (pz_q < zl_q) || (pz_q > zh_q);
  assign sat_dim = (dv_quo[DNW-1:PW] != '0);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cmem[mem_wa] <= mem_wc;
      smem[mem_wa] <= mem_ws;
    end
    crd_q <= cmem[idx_q];
    srd_q <= smem[idx_q];
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wc = '0;
    mem_ws = '0;
    if (st_q == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
    end else if (st_q == S_UPD && !upd_full) begin
      mem_we = 1'b1;
      mem_wc = upd_cnt;
      mem_ws = upd_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      clr_q <= '0;
      tot_q <= '0;
      xl_q <= '0; xh_q <= CoordW'(4096);
      yl_q <= '0; yh_q <= CoordW'(4096);
      zl_q <= '0; zh_q <= CoordW'(1024);
      vs_q <= SizeW'(256);
      ax_q <= '0;
      ovf_q <= 1'b0;
      dim_q <= '{default: '0};
      cell_q <= '{default: '0};
      stat_q <= StAdded;
      idx_q <= '0;
      cnt_q <= '0;
      mean_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegXLow: xl_q <= cfg_data_i;
          RegXHigh: xh_q <= cfg_data_i;
          RegYLow: yl_q <= cfg_data_i;
          RegYHigh: yh_q <= cfg_data_i;
          RegZLow: zl_q <= cfg_data_i;
          RegZHigh: zh_q <= cfg_data_i;
          RegVSize: vs_q <= cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
      unique case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(MAX_VOXELS - 1)) st_q <= S_IDLE;
        end
        S_IDLE: if (in_valid_i) begin
          st_q <= S_DIM;
          ax_q <= '0;
          ovf_q <= 1'b0;
        end
        S_DIM: st_q <= S_DIMW;
        S_DIMW: if (dv_done) begin
          dim_q[ax_q] <= sat_dim ? '1 : ((dv_quo[PW-1:0] == '0) ? PW'(1) : dv_quo[PW-1:0]);
          if (ax_q == 2'd2) begin
            st_q <= S_SZ1;
            ax_q <= '0;
          end else begin
            ax_q <= ax_q + 1'b1;
            st_q <= S_DIM;
          end
        end
        S_SZ1: st_q <= S_SZ1W;
        S_SZ1W: if (mu_done) begin
          if (mu_p[2*PW-1:PW] != '0) ovf_q <= 1'b1;
          st_q <= S_SZ2;
        end
        S_SZ2: st_q <= S_SZ2W;
        S_SZ2W: if (mu_done) begin
          if (ovf_q || mu_p[2*PW-1:PW] != '0 || mu_p > (2*PW)'(MAX_VOXELS)) begin
            stat_q <= StTooBig;
            st_q <= S_OUT;
          end else if (outside) begin
            stat_q <= StOutside;
            st_q <= S_OUT;
          end else begin
            st_q <= S_CELL;
          end
          idx_q <= '0; cnt_q <= '0; mean_q <= '0;
        end
        S_CELL: st_q <= S_CELLW;
        S_CELLW: if (dv_done) begin
          cell_q[ax_q] <= (dv_quo >= DNW'(dim_q[ax_q])) ? dim_q[ax_q] - 1'b1
                                                         : dv_quo[PW-1:0];
          if (ax_q == 2'd2) st_q <= S_IX1;
          else begin
            ax_q <= ax_q + 1'b1;
            st_q <= S_CELL;
          end
        end
        S_IX1: st_q <= S_IX1W;
        S_IX1W: if (mu_done) begin
          // (i*cols + j)*ch + k, small since grid fits the store
          idx_q <= (mu_p[AW-1:0] + cell_q[1][AW-1:0]) * dim_q[2][AW-1:0]
                 + cell_q[2][AW-1:0];
          st_q <= S_RD;
        end
        S_RD: st_q <= S_UPD;
        S_UPD: begin
          stat_q <= upd_full ? StFull : StAdded;
          cnt_q <= upd_cnt;
          if (!upd_full && tot_q != '1) tot_q <= tot_q + 1'b1;
          neg_q <= upd_sum[SW-1];
          st_q <= S_MEANW;
        end
        S_MEANW: if (dv_done) begin
          mean_q <= neg_q ? -CoordW'(dv_quo) : CoordW'(dv_quo);
          st_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      pz_q <= point_z_i;
    end
  end

  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign status_o = stat_q;
  assign voxel_index_o = 12'(idx_q);
  assign voxel_points_o = 16'(cnt_q);
  assign voxel_mean_z_o = mean_q;
  assign total_points_o = tot_q;

  `VG_ASSERT_IMPL(a_no_both, clk_i, rst_ni, 1'b1, !(in_ready_o && out_valid_o),
    "input and output open together")
  `VG_ASSERT_NEXT(a_tot_mono, clk_i, rst_ni, 1'b1, total_points_o >= $past(total_points_o),
    "total count went down")
  `VG_ASSERT_IMPL(a_clr_quiet, clk_i, rst_ni, st_q == S_CLR, !in_ready_o && !out_valid_o,
    "handshake during clear")
endmodule
